// ===== design/hvn_pkg.sv =====
package hvn_pkg;

    // Field widths of the result item
    localparam int POS_X_W  = 28;
    localparam int POS_Y_W  = 26;
    localparam int POS_Z_W  = 28;
    localparam int NRM_XZ_W = 16;
    localparam int NRM_Y_W  = 15;
    localparam int TEX_W    = 17;
    localparam int VIDX_W   = 24;
    localparam int OUT_DATA_W = 192;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_UP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_STEP       = 3'd6;

    // Sequencer step counts (last step index of each phase)
    localparam int STEP_W     = 6;
    localparam int READ_LAST  = 5;
    localparam int ARITH_LAST = 10;
    localparam int SQRT_LAST  = 31;
    localparam int DIV_LAST   = 15;
    localparam int COMP_LAST  = 2;

    // Normal component selectors
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic [NRM_Y_W-1:0] NRM_ONE = 15'h7FFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_ARITH,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_OUT,
        ST_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_READ,
        OP_ARITH,
        OP_SQRT,
        OP_DINIT,
        OP_DIV,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
        logic [1:0]        sel;
        logic              emitted;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic m_zero;
    } sts_t;

    typedef struct packed {
        logic [POS_X_W-1:0]         pos_x;
        logic signed [POS_Y_W-1:0]  pos_y;
        logic [POS_Z_W-1:0]         pos_z;
        logic signed [NRM_XZ_W-1:0] normal_x;
        logic [NRM_Y_W-1:0]         normal_y;
        logic signed [NRM_XZ_W-1:0] normal_z;
        logic [TEX_W-1:0]           tex_u;
        logic [TEX_W-1:0]           tex_v;
        logic [VIDX_W-1:0]          vertex_index;
        logic                       quad_valid;
        logic                       last_vertex;
    } res_t;

endpackage

// ===== design/hvn_ram.sv =====
module hvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8193
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hvn_ctrl.sv =====
module hvn_ctrl
    import hvn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_free,
    output logic out_load,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        sel_reg, sel_next;
    logic              emit_reg, emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sel_reg   <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        sel_next    = sel_reg;
        emit_next   = emit_reg;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.step    = step_reg;
        cmd.sel     = sel_reg;
        cmd.emitted = emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                emit_next  = sts.emit;
                step_next  = '0;
                sel_next   = COMP_X;
                state_next = sts.emit ? ST_READ : ST_COMMIT;
            end
            ST_READ:
            begin
                cmd.op = OP_READ;
                if (step_reg == STEP_W'(READ_LAST))
                begin
                    step_next  = '0;
                    state_next = ST_ARITH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ARITH:
            begin
                cmd.op = OP_ARITH;
                if (step_reg == STEP_W'(ARITH_LAST))
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (step_reg == STEP_W'(SQRT_LAST))
                begin
                    step_next  = '0;
                    state_next = ST_DINIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DINIT:
            begin
                // zero magnitude: fixed straight-up normal, no divisions
                if (sts.m_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_DINIT;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (step_reg == STEP_W'(DIV_LAST))
                begin
                    step_next = '0;
                    if (sel_reg == 2'(COMP_LAST))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_DINIT;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/hvn_dpath.sv =====
module hvn_dpath
    import hvn_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        in_action,
    input  logic [7:0]  in_sample,
    input  logic        restart,
    input  logic [12:0] grid_width,
    input  logic [12:0] grid_height,
    input  logic [15:0] grid_spacing,
    input  logic [23:0] height_scale,
    input  logic [23:0] height_offset,
    input  logic [15:0] normal_up,
    input  logic [16:0] uv_step,
    output res_t        res
);

    localparam int RD = 2 * MAX_WIDTH + 1;
    localparam int AW = $clog2(RD);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = WW + HW;

    // frame counters
    logic [CW-1:0] samp_reg, vert_reg;
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [AW-1:0] wp_reg, vp_reg;

    logic       act_reg;
    logic [7:0] hs_reg;
    logic [7:0] sc_reg, su_reg, sd_reg, sl_reg, sr_reg;

    logic [30:0] a_reg, cz_reg;
    logic [63:0] mul_reg, acc_reg;
    logic [63:0] x_reg, r_reg, bit_reg;
    logic [32:0] rem_reg;
    logic [15:0] lo_reg, q_reg;
    logic [15:0] qx_reg, qy_reg, qz_reg;
    logic signed [POS_Y_W-1:0] py_reg;
    logic [TEX_W-1:0]   tu_reg, tv_reg;
    logic [POS_X_W-1:0] px_reg;
    logic [POS_Z_W-1:0] pz_reg;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [CW-1:0] total, tot_m1;
    logic [CW:0]   need_raw, need;
    logic          accept_ok, col_first, col_last, row_first, row_last;

    logic [AW:0]   vp_ext, w_ext, vp_pw, vp_mw, vp_p1, vp_m1;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          ram_we;

    logic [7:0]  dx, dz;
    logic        negx, negz;
    logic [30:0] bq;
    logic [31:0] op_a, op_b;
    logic [32:0] py_round;
    logic [63:0] sq_t;
    logic [32:0] m_val;
    logic [30:0] mag;
    logic [46:0] num;
    logic [33:0] dv_t;
    logic [15:0] q_next;
    logic [32:0] dv_rem;
    logic [14:0] sat_x, sat_y, sat_z;
    logic        m_zero;

    always_comb
    begin
        if (grid_width < 13'd2)
        begin
            eff_w = WW'(2);
        end
        else if (32'(grid_width) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(grid_width);
        end
        if (grid_height < 13'd2)
        begin
            eff_h = HW'(2);
        end
        else if (32'(grid_height) > MAX_HEIGHT)
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(grid_height);
        end
    end

    assign total     = CW'(eff_w) * CW'(eff_h);
    assign tot_m1    = total - 1'b1;
    assign need_raw  = (CW + 1)'(vert_reg) + (CW + 1)'(eff_w);
    assign need      = (need_raw > (CW + 1)'(tot_m1)) ? (CW + 1)'(tot_m1) : need_raw;
    assign sts.emit  = (vert_reg < total) && ((CW + 1)'(samp_reg) > need);
    assign accept_ok = !act_reg && (samp_reg < total);

    assign col_first = (col_reg == '0);
    assign row_first = (row_reg == '0);
    assign col_last  = (WW'(col_reg) == eff_w - 1'b1);
    assign row_last  = (HW'(row_reg) == eff_h - 1'b1);

    // neighbour addresses in the ring
    assign vp_ext = (AW + 1)'(vp_reg);
    assign w_ext  = (AW + 1)'(eff_w);

    always_comb
    begin
        vp_pw = vp_ext + w_ext;
        if (vp_pw >= (AW + 1)'(RD))
        begin
            vp_pw = vp_pw - (AW + 1)'(RD);
        end
        vp_mw = (vp_ext >= w_ext) ? (vp_ext - w_ext) : (vp_ext + (AW + 1)'(RD) - w_ext);
        vp_p1 = vp_ext + 1'b1;
        if (vp_p1 >= (AW + 1)'(RD))
        begin
            vp_p1 = '0;
        end
        vp_m1 = (vp_ext == '0) ? (AW + 1)'(RD - 1) : (vp_ext - 1'b1);
        case (cmd.step)
            6'd1:    raddr = row_first ? vp_reg : AW'(vp_mw);
            6'd2:    raddr = row_last  ? vp_reg : AW'(vp_pw);
            6'd3:    raddr = col_first ? vp_reg : AW'(vp_m1);
            6'd4:    raddr = col_last  ? vp_reg : AW'(vp_p1);
            default: raddr = vp_reg;
        endcase
    end

    assign ram_we = (cmd.op == OP_COMMIT) && accept_ok;

    hvn_ram #(
        .WIDTH (8),
        .DEPTH (RD)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (hs_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign negx = (su_reg < sd_reg);
    assign negz = (sl_reg < sr_reg);
    assign dx   = negx ? (sd_reg - su_reg) : (su_reg - sd_reg);
    assign dz   = negz ? (sr_reg - sl_reg) : (sl_reg - sr_reg);
    assign bq   = {normal_up, 15'b0};

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.step)
            6'd0:    begin op_a = 32'(dx);      op_b = 32'(height_scale); end
            6'd1:    begin op_a = 32'(dz);      op_b = 32'(height_scale); end
            6'd2:    begin op_a = 32'(a_reg);   op_b = 32'(a_reg);        end
            6'd3:    begin op_a = 32'(bq);      op_b = 32'(bq);           end
            6'd4:    begin op_a = 32'(cz_reg);  op_b = 32'(cz_reg);       end
            6'd5:    begin op_a = 32'(sc_reg);  op_b = 32'(height_scale); end
            6'd6:    begin op_a = 32'(col_reg); op_b = 32'(uv_step);      end
            6'd7:    begin op_a = 32'(row_reg); op_b = 32'(uv_step);      end
            6'd8:    begin op_a = 32'(row_reg); op_b = 32'(grid_spacing); end
            6'd9:    begin op_a = 32'(col_reg); op_b = 32'(grid_spacing); end
            default: begin op_a = '0;           op_b = '0;                end
        endcase
    end

    assign py_round = {1'b0, mul_reg[31:0]} + 33'd128;
    assign sq_t     = r_reg + bit_reg;
    assign m_val    = r_reg[32:0];
    assign m_zero   = (r_reg == '0);
    assign sts.m_zero = m_zero;

    always_comb
    begin
        case (cmd.sel)
            COMP_X:  mag = a_reg;
            COMP_Y:  mag = bq;
            default: mag = cz_reg;
        endcase
    end

    // (mag * 32768 + m/2) / m, restoring, one quotient bit per step
    assign num  = {mag, 15'b0} + 47'(m_val >> 1);
    assign dv_t = {rem_reg, lo_reg[15]};

    always_comb
    begin
        if (dv_t >= {1'b0, m_val})
        begin
            dv_rem = 33'(dv_t - {1'b0, m_val});
            q_next = {q_reg[14:0], 1'b1};
        end
        else
        begin
            dv_rem = dv_t[32:0];
            q_next = {q_reg[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                act_reg <= in_action;
                hs_reg  <= in_sample;
            end
            OP_READ:
            begin
                case (cmd.step)
                    6'd1:    sc_reg <= rdata;
                    6'd2:    su_reg <= rdata;
                    6'd3:    sd_reg <= rdata;
                    6'd4:    sl_reg <= rdata;
                    6'd5:    sr_reg <= rdata;
                    default: ;
                endcase
            end
            OP_ARITH:
            begin
                mul_reg <= 64'(op_a) * 64'(op_b);
                case (cmd.step)
                    6'd1: a_reg   <= mul_reg[31:1];
                    6'd2: cz_reg  <= mul_reg[31:1];
                    6'd3: acc_reg <= mul_reg;
                    6'd4: acc_reg <= acc_reg + mul_reg;
                    6'd5: acc_reg <= acc_reg + mul_reg;
                    6'd6: py_reg  <= POS_Y_W'({1'b0, py_round[32:8]})
                                     + {{2{height_offset[23]}}, height_offset};
                    6'd7: tu_reg  <= (mul_reg > 64'd65536) ? 17'h10000 : mul_reg[16:0];
                    6'd8: tv_reg  <= (mul_reg >= 64'd65536) ? 17'h0
                                     : 17'h10000 - {1'b0, mul_reg[15:0]};
                    6'd9: px_reg  <= mul_reg[POS_X_W-1:0];
                    6'd10:
                    begin
                        pz_reg  <= mul_reg[POS_Z_W-1:0];
                        x_reg   <= acc_reg;
                        r_reg   <= '0;
                        bit_reg <= 64'h4000_0000_0000_0000;
                    end
                    default: ;
                endcase
            end
            OP_SQRT:
            begin
                if (x_reg >= sq_t)
                begin
                    x_reg <= x_reg - sq_t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DINIT:
            begin
                rem_reg <= 33'(num[46:16]);
                lo_reg  <= num[15:0];
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= dv_rem;
                lo_reg  <= {lo_reg[14:0], 1'b0};
                q_reg   <= q_next;
                if (cmd.step == STEP_W'(DIV_LAST))
                begin
                    case (cmd.sel)
                        COMP_X:  qx_reg <= q_next;
                        COMP_Y:  qy_reg <= q_next;
                        default: qz_reg <= q_next;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_reg <= '0;
            vert_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            wp_reg   <= '0;
            vp_reg   <= '0;
        end
        else if (restart)
        begin
            samp_reg <= '0;
            vert_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            wp_reg   <= '0;
            vp_reg   <= '0;
        end
        else if (cmd.op == OP_COMMIT)
        begin
            if (accept_ok)
            begin
                samp_reg <= samp_reg + 1'b1;
                wp_reg   <= (wp_reg == AW'(RD - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (cmd.emitted)
            begin
                if (vert_reg + 1'b1 >= total)
                begin
                    // frame complete
                    samp_reg <= '0;
                    vert_reg <= '0;
                    col_reg  <= '0;
                    row_reg  <= '0;
                    wp_reg   <= '0;
                    vp_reg   <= '0;
                end
                else
                begin
                    vert_reg <= vert_reg + 1'b1;
                    vp_reg   <= AW'(vp_p1);
                    if (col_last)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign sat_x = (qx_reg > 16'd32767) ? 15'h7FFF : qx_reg[14:0];
    assign sat_y = (qy_reg > 16'd32767) ? 15'h7FFF : qy_reg[14:0];
    assign sat_z = (qz_reg > 16'd32767) ? 15'h7FFF : qz_reg[14:0];

    always_comb
    begin
        res.pos_x = px_reg;
        res.pos_y = py_reg;
        res.pos_z = pz_reg;
        if (m_zero)
        begin
            res.normal_x = '0;
            res.normal_y = NRM_ONE;
            res.normal_z = '0;
        end
        else
        begin
            res.normal_x = negx ? -{1'b0, sat_x} : {1'b0, sat_x};
            res.normal_y = sat_y;
            res.normal_z = negz ? -{1'b0, sat_z} : {1'b0, sat_z};
        end
        res.tex_u        = tu_reg;
        res.tex_v        = tv_reg;
        res.vertex_index = VIDX_W'(vert_reg);
        res.quad_valid   = !col_last && !row_last;
        res.last_vertex  = (vert_reg == tot_m1);
    end

endmodule

// ===== design/heightmap_vertex_normal_generator_unit.sv =====
// Heightmap vertex and normal generator.
// s_axis carries one request per item: tuser = 1 drains a pending vertex,
// tuser = 0 pushes the height byte in tdata. Samples arrive in raster order.
// m_axis returns at most one vertex per request; tlast marks the last vertex
// of the grid. Vertices lag the samples by one row, so drain requests flush
// the tail of the frame.
// cfg writes one register (index 0..6) per cycle, cfg_ready is always high;
// a width or height write restarts the frame.
// A request that yields no vertex skips the computation. One that yields a
// vertex passes through ring reads of the sample and its four neighbours,
// 11 steps on a single 32x32 multiplier, a 32-step square root and three
// 16-step restoring divisions for the normal (skipped when it is degenerate).
// The vertex sits in an output register; the core returns to accept the next
// request while it waits, and only stalls if a second vertex is ready before
// the first has been taken.
// Reset clears the frame counters and loads the default registers; the sample
// ring is not cleared, since no entry is read before it is written.
module heightmap_vertex_normal_generator_unit
    import hvn_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // height_sample
    input  logic [0:0]            s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
    // vertex_index, quad_valid, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // last_vertex
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [12:0] grid_width_reg, grid_height_reg;
    logic [15:0] grid_spacing_reg, normal_up_reg;
    logic [23:0] height_scale_reg, height_offset_reg;
    logic [16:0] uv_step_reg;

    logic  out_valid_reg;
    res_t  out_res_reg;
    res_t  res;
    cmd_t  cmd;
    sts_t  sts;
    logic  out_free, out_load, restart, cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign restart   = cfg_we && ((cfg_index == CFG_GRID_WIDTH)
                                  || (cfg_index == CFG_GRID_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= 13'd256;
            grid_height_reg   <= 13'd256;
            grid_spacing_reg  <= 16'd50;
            height_scale_reg  <= 24'd187193;
            height_offset_reg <= 24'd12493;
            normal_up_reg     <= 16'd100;
            uv_step_reg       <= 17'd257;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:    grid_width_reg    <= cfg_data[12:0];
                CFG_GRID_HEIGHT:   grid_height_reg   <= cfg_data[12:0];
                CFG_GRID_SPACING:  grid_spacing_reg  <= cfg_data[15:0];
                CFG_HEIGHT_SCALE:  height_scale_reg  <= cfg_data;
                CFG_HEIGHT_OFFSET: height_offset_reg <= cfg_data;
                CFG_NORMAL_UP:     normal_up_reg     <= cfg_data[15:0];
                CFG_UV_STEP:       uv_step_reg       <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    hvn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .sts      (sts),
        .cmd      (cmd)
    );

    hvn_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_action     (s_axis_tuser[0]),
        .in_sample     (s_axis_tdata),
        .restart       (restart),
        .grid_width    (grid_width_reg),
        .grid_height   (grid_height_reg),
        .grid_spacing  (grid_spacing_reg),
        .height_scale  (height_scale_reg),
        .height_offset (height_offset_reg),
        .normal_up     (normal_up_reg),
        .uv_step       (uv_step_reg),
        .res           (res)
    );

    // output register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.last_vertex;
    assign m_axis_tdata  = {4'b0,
                            out_res_reg.quad_valid,
                            out_res_reg.vertex_index,
                            out_res_reg.tex_v,
                            out_res_reg.tex_u,
                            out_res_reg.normal_z,
                            out_res_reg.normal_y,
                            out_res_reg.normal_x,
                            out_res_reg.pos_z,
                            out_res_reg.pos_y,
                            out_res_reg.pos_x};

endmodule

// ===== sim/tb_heightmap_vertex_normal_generator_unit.sv =====
module tb_heightmap_vertex_normal_generator_unit;
    import hvn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_LEN = 2 * 4096 + 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    heightmap_vertex_normal_generator_unit dut (.*);

    always #6 clk = ~clk;

    // predictor state and register copy
    logic [7:0]  ring_mem [RING_LEN];
    int unsigned heights_in, verts_out, col_pos, row_pos;
    int unsigned r_width, r_height, r_spacing, r_scale, r_offset, r_up, r_uv;

    res_t        vertex_q[$];
    int          errors = 0;
    int          items_sent = 0;
    int          vertices_seen = 0;
    int          frames_done = 0;
    bit          steady = 1'b0;   // no idling on either side while set
    int          rx_hold = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= r + bit_v) begin
                x -= r + bit_v;
                r = (r >> 1) + bit_v;
            end else begin
                r >>= 1;
            end
            bit_v >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned unit_comp(longint unsigned mag, longint unsigned m);
        longint unsigned q;
        if (m == 0) return 0;
        q = (mag * 32768 + m / 2) / m;
        return (q > 32767) ? 32767 : q;
    endfunction

    function automatic int unsigned clamp_dim(int unsigned d);
        if (d < 2) return 2;
        if (d > 4096) return 4096;
        return d;
    endfunction

    task automatic restart_grid();
        heights_in = 0;
        verts_out  = 0;
        col_pos    = 0;
        row_pos    = 0;
    endtask

    task automatic reset_regs();
        restart_grid();
        r_width = 256; r_height = 256; r_spacing = 50; r_scale = 187193;
        r_offset = 12493; r_up = 100; r_uv = 257;
    endtask

    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GRID_WIDTH:    begin r_width = val & 24'h1FFF; restart_grid(); end
            CFG_GRID_HEIGHT:   begin r_height = val & 24'h1FFF; restart_grid(); end
            CFG_GRID_SPACING:  r_spacing = val & 24'hFFFF;
            CFG_HEIGHT_SCALE:  r_scale = val;
            CFG_HEIGHT_OFFSET: r_offset = val;
            CFG_NORMAL_UP:     r_up = val & 24'hFFFF;
            CFG_UV_STEP:       r_uv = val & 24'h1FFFF;
            default: ;
        endcase
    endtask

    // one request into the predictor: maybe one vertex, then the sample is stored
    task automatic vertex_predict(bit drain, logic [7:0] smp);
        int unsigned w, h, total, need, v;
        longint unsigned c, up, dn, lf, rt, a, cz, b, m, nx, ny, nz, tu, rv, tv, s;
        longint off, py;
        bit negx, negz;
        bit accept;
        res_t r;
        w = clamp_dim(r_width);
        h = clamp_dim(r_height);
        total = w * h;
        // decided before any frame restart below
        accept = !drain && heights_in < total;
        if (verts_out < total) begin
            v = verts_out;
            need = v + w;
            if (need > total - 1) need = total - 1;
            if (heights_in > need) begin
                s  = r_scale;
                c  = ring_mem[v % RING_LEN];
                up = (row_pos > 0)     ? ring_mem[(v - w) % RING_LEN] : c;
                dn = (row_pos < h - 1) ? ring_mem[(v + w) % RING_LEN] : c;
                lf = (col_pos > 0)     ? ring_mem[(v - 1) % RING_LEN] : c;
                rt = (col_pos < w - 1) ? ring_mem[(v + 1) % RING_LEN] : c;
                negx = up < dn;
                negz = lf < rt;
                a  = ((negx ? dn - up : up - dn) * s) >> 1;
                cz = ((negz ? rt - lf : lf - rt) * s) >> 1;
                b  = longint'(r_up) << 15;
                m  = root64(a * a + b * b + cz * cz);
                if (m == 0) begin
                    nx = 0; ny = 32767; nz = 0;
                end else begin
                    nx = unit_comp(a, m);
                    ny = unit_comp(b, m);
                    nz = unit_comp(cz, m);
                end
                if (negx) nx = (0 - nx) & 16'hFFFF;
                if (negz) nz = (0 - nz) & 16'hFFFF;
                off = r_offset;
                if (r_offset & 24'h800000) off -= 64'h1000000;
                py = longint'((c * s + 128) >> 8) + off;
                tu = longint'(col_pos) * r_uv;
                if (tu > 65536) tu = 65536;
                rv = longint'(row_pos) * r_uv;
                tv = (rv >= 65536) ? 0 : 65536 - rv;
                r.pos_x        = POS_X_W'(longint'(row_pos) * r_spacing);
                r.pos_y        = py[POS_Y_W-1:0];
                r.pos_z        = POS_Z_W'(longint'(col_pos) * r_spacing);
                r.normal_x     = nx[NRM_XZ_W-1:0];
                r.normal_y     = ny[NRM_Y_W-1:0];
                r.normal_z     = nz[NRM_XZ_W-1:0];
                r.tex_u        = tu[TEX_W-1:0];
                r.tex_v        = tv[TEX_W-1:0];
                r.vertex_index = VIDX_W'(v);
                r.quad_valid   = (col_pos != w - 1) && (row_pos != h - 1);
                r.last_vertex  = (v == total - 1);
                vertex_q = {vertex_q, r};
                verts_out++;
                col_pos++;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos++;
                end
                if (verts_out >= total) begin
                    restart_grid();
                    frames_done++;
                end
            end
        end
        if (accept) begin
            ring_mem[heights_in % RING_LEN] = smp;
            heights_in++;
        end
    endtask

    // called at a rising edge; leaves tvalid high for the next request
    task automatic send_item(bit drain, logic [7:0] smp);
        int g;
        g = steady ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drain;
        s_axis_tdata  <= smp;
        do @(posedge clk); while (!s_axis_tready);
        vertex_predict(drain, smp);
        items_sent++;
    endtask

    task automatic push_height(logic [7:0] smp);
        send_item(1'b0, smp);
    endtask

    task automatic drain_one();
        send_item(1'b1, 8'($urandom));
    endtask

    // pause until every vertex has come, then allow for a request still in flight
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(int unsigned w, int unsigned h);
        cfg_write(CFG_GRID_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic set_shape(int unsigned sp, int unsigned sc, int unsigned off,
                             int unsigned up, int unsigned uv);
        cfg_write(CFG_GRID_SPACING, CFG_DATA_W'(sp));
        cfg_write(CFG_HEIGHT_SCALE, CFG_DATA_W'(sc));
        cfg_write(CFG_HEIGHT_OFFSET, CFG_DATA_W'(off));
        cfg_write(CFG_NORMAL_UP, CFG_DATA_W'(up));
        cfg_write(CFG_UV_STEP, CFG_DATA_W'(uv));
    endtask

    // whole frame: samples, stray drains, surplus pushes, then the flush
    task automatic run_frame(int unsigned w, int unsigned h, int unsigned mode);
        logic [7:0] smp;
        for (int unsigned i = 0; i < w * h; i++) begin
            case (mode)
                0:       smp = 8'($urandom);
                1:       smp = 8'd77;
                default: smp = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            if ($urandom_range(0, 9) == 0) drain_one();
            push_height(smp);
        end
        if ($urandom_range(0, 3) == 0) push_height(8'($urandom));
        for (int unsigned i = 0; i < w + 2; i++) drain_one();
    endtask

    task automatic test_defaults();
        // default 256x256 grid: no vertex can come from a handful of samples
        for (int i = 0; i < 6; i++) push_height(8'($urandom));
        drain_one();
        wait_idle();
    endtask

    task automatic test_extremes();
        set_grid(3, 3);
        set_shape(65535, 24'hFFFFFF, 24'h800000, 65535, 65536);
        push_height(8'h00); push_height(8'hFF); push_height(8'h00);
        push_height(8'hFF); push_height(8'h00); push_height(8'hFF);
        push_height(8'h00); push_height(8'hFF); push_height(8'h00);
        push_height(8'h55);              // beyond the frame, ignored
        for (int i = 0; i < 5; i++) drain_one();
        drain_one();                     // nothing pending
        wait_idle();
        // flat heights with zero vertical part: degenerate normal
        set_shape(1, 0, 24'h7FFFFF, 0, 24'h1FFFF);
        set_grid(2, 2);
        run_frame(2, 2, 1);
        wait_idle();
    endtask

    task automatic test_dim_limits();
        // clamped widths and heights, only part of each frame is sent
        set_grid(24'h1FFF, 0);
        for (int i = 0; i < 8; i++) push_height(8'($urandom));
        drain_one();
        wait_idle();
        set_grid(0, 24'h1FFF);
        for (int i = 0; i < 12; i++) push_height(8'($urandom));
        for (int i = 0; i < 3; i++) drain_one();
        wait_idle();
        set_grid(4096, 4096);
        for (int i = 0; i < 5; i++) push_height(8'($urandom));
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned w, h;
        while (items_sent < 740) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) w = $urandom_range(7, 24);
            else w = $urandom_range(2, 6);
            h = $urandom_range(2, 6);
            set_grid(w, h);
            set_shape($urandom_range(0, 3) == 0 ? 65535 : $urandom_range(1, 65535),
                      $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom),
                      24'($urandom),
                      $urandom_range(0, 7) == 0 ? 1 : $urandom_range(0, 65535),
                      $urandom_range(0, 131071));
            run_frame(w, h, ($urandom_range(0, 5) == 0) ? 2 : 0);
            // sometimes a broken frame: cut short by the next grid write
            if ($urandom_range(0, 5) == 0) begin
                for (int i = 0; i < w + 1; i++) push_height(8'($urandom));
                drain_one();
            end
            wait_idle();
        end
        steady = 1'b0;
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0) rx_hold <= gap_len();
        end
    end

    always @(posedge clk) begin
        res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            vertices_seen++;
            if (vertex_q.size() == 0) begin
                $error("vertex %0h with none expected", m_axis_tdata[186:163]);
                errors++;
            end else begin
                e = vertex_q.pop_front();
                check_field("pos_x", e.pos_x, m_axis_tdata[27:0]);
                check_field("pos_y", e.pos_y[POS_Y_W-1:0], m_axis_tdata[53:28]);
                check_field("pos_z", e.pos_z, m_axis_tdata[81:54]);
                check_field("normal_x", e.normal_x[NRM_XZ_W-1:0], m_axis_tdata[97:82]);
                check_field("normal_y", e.normal_y, m_axis_tdata[112:98]);
                check_field("normal_z", e.normal_z[NRM_XZ_W-1:0], m_axis_tdata[128:113]);
                check_field("tex_u", e.tex_u, m_axis_tdata[145:129]);
                check_field("tex_v", e.tex_v, m_axis_tdata[162:146]);
                check_field("vertex_index", e.vertex_index, m_axis_tdata[186:163]);
                check_field("quad_valid", e.quad_valid, m_axis_tdata[187]);
                check_field("last_vertex", e.last_vertex, m_axis_tlast);
            end
        end
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        reset_regs();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        test_dim_limits();
        test_random_frames();
        wait_idle();
        if (vertex_q.size() != 0) begin
            $error("%0d vertices never arrived", vertex_q.size());
            errors++;
        end
        $display("%0d requests, %0d vertices checked, %0d full frames", items_sent,
                 vertices_seen, frames_done);
        $display("grids from 2x2 up to clamped limits, register extremes, idle and stall gaps");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/hvn_pkg.sv
design/hvn_ram.sv
design/hvn_ctrl.sv
design/hvn_dpath.sv
design/heightmap_vertex_normal_generator_unit.sv
sim/tb_heightmap_vertex_normal_generator_unit.sv
